// ----- rtl/core/pss_pkg.sv -----
// Shared types and constants of the plucked string synthesiser.
package pss_pkg;

  // Configuration register indexes and widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUCK_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_DAMPING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_DECAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCITE_COEF  = 3'd4;

  // Register reset values.
  localparam logic [27:0] DELAY_LENGTH_RST = 28'd14206416;
  localparam logic [12:0] PLUCK_LENGTH_RST = 13'd216;
  localparam logic [14:0] LOOP_DAMPING_RST = 15'd16384;
  localparam logic [15:0] LOOP_DECAY_RST   = 16'd32440;
  localparam logic [14:0] EXCITE_COEF_RST  = 15'd7537;

  // Noise generator seed loaded at reset and at each pluck.
  localparam logic [31:0] SEED_INIT = 32'h9E37_79B9;

  typedef struct packed {
    logic               channel;
    logic signed [15:0] trigger;
  } in_item_t;

  typedef struct packed {
    logic               channel_out;
    logic signed [15:0] sample_out;
  } out_item_t;

  // Strobes from the controller, one per datapath step.
  typedef struct packed {
    logic accept;
    logic addr;
    logic rd0;
    logic rd1;
    logic intp;
    logic ysat;
    logic filt;
    logic gain;
    logic write;
  } pss_cmd_t;

  typedef struct packed {
    logic red_busy;
    logic out_free;
  } pss_status_t;

endpackage

// ----- rtl/core/pss_controller.sv -----
// Sequencing state machine of the plucked string synthesiser.
module pss_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pss_pkg::pss_status_t status_i,
  output pss_pkg::pss_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_ADDR  = 9'b000000010,
    ST_RD0   = 9'b000000100,
    ST_RD1   = 9'b000001000,
    ST_INTP  = 9'b000010000,
    ST_YSAT  = 9'b000100000,
    ST_FILT  = 9'b001000000,
    ST_GAIN  = 9'b010000000,
    ST_WRITE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE) && !status_i.red_busy;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = in_ready && in_valid;
    cmd_o.addr   = (state_r == ST_ADDR);
    cmd_o.rd0    = (state_r == ST_RD0);
    cmd_o.rd1    = (state_r == ST_RD1);
    cmd_o.intp   = (state_r == ST_INTP);
    cmd_o.ysat   = (state_r == ST_YSAT);
    cmd_o.filt   = (state_r == ST_FILT);
    cmd_o.gain   = (state_r == ST_GAIN);
    cmd_o.write  = (state_r == ST_WRITE) && status_i.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_o.accept) state_nxt = ST_ADDR;
      end
      ST_ADDR:  state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_INTP;
      ST_INTP:  state_nxt = ST_YSAT;
      ST_YSAT:  state_nxt = ST_FILT;
      ST_FILT:  state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (status_i.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted item always starts the address step.
  a_accept_to_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.accept |=> state_r == ST_ADDR)
    else $error("accepted item did not start address step");

  // A full output register holds the sequence in the write step.
  a_write_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) && !status_i.out_free |=> state_r == ST_WRITE)
    else $error("write step left while output register full");

endmodule

// ----- rtl/core/pss_datapath.sv -----
// Datapath of the plucked string synthesiser: registers, delay memory and arithmetic.
module pss_datapath #(
  parameter int DELAY_DEPTH = 4096,
  parameter int CHANNELS    = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  pss_pkg::in_item_t                 in_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output pss_pkg::out_item_t                out_data,
  input  pss_pkg::pss_cmd_t                 cmd,
  output pss_pkg::pss_status_t              status
);

  localparam int AW        = $clog2(DELAY_DEPTH);
  localparam int PW        = AW + 16;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS << AW;
  localparam int MAW       = $clog2(MEM_DEPTH);
  localparam logic [PW:0]   SPAN      = (PW + 1)'(DELAY_DEPTH) << 16;
  localparam logic [63:0]   SPAN64    = 64'(DELAY_DEPTH) << 16;
  localparam logic [AW-1:0] LAST_IDX  = AW'(DELAY_DEPTH - 1);
  localparam int RED_STEPS = (DELAY_DEPTH >= 4096) ? 0 :
                             $clog2((4096 + DELAY_DEPTH - 1) / DELAY_DEPTH);
  localparam int RCW       = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
  localparam logic [27:0]   RED_RESET = 28'(64'(pss_pkg::DELAY_LENGTH_RST) % SPAN64);

  function automatic logic signed [15:0] rnd_sat(input logic signed [33:0] v,
                                                 input int n);
    logic signed [33:0] t;
    t = (v + (34'sd1 <<< (n - 1))) >>> n;
    if (t > 34'sd32767) return 16'sh7FFF;
    else if (t < -34'sd32768) return 16'sh8000;
    else return t[15:0];
  endfunction

  // Configuration.
  logic [12:0]     pluck_r;
  logic [14:0]     damp_r;
  logic [15:0]     decay_r;
  logic [14:0]     excite_r;
  logic [27:0]     red_r;
  logic [RCW-1:0]  red_cnt_r;
  logic [63:0]     red_step;

  // Per-channel state.
  logic signed [15:0] lf_r    [CHANNELS];
  logic signed [15:0] bf_r    [CHANNELS];
  logic signed [15:0] prev_r  [CHANNELS];
  logic [AW-1:0]      wi_r    [CHANNELS];
  logic               wrap_r  [CHANNELS];
  logic [12:0]        burst_r [CHANNELS];
  logic [31:0]        seed_r  [CHANNELS];

  // Item in flight.
  logic               ch_r;
  logic [CH_W-1:0]    ch_idx_r;
  logic               ch_ok_r;
  logic signed [15:0] trig_r;
  logic [AW-1:0]      i0_r, i1_r;
  logic [15:0]        frac_r;
  logic signed [15:0] rdata_r;
  logic               rvalid_r;
  logic signed [33:0] prod0_r, sum_r;
  logic signed [15:0] y_r, fb_r, wv_r;
  logic               out_valid_r;
  pss_pkg::out_item_t out_data_r;

  logic signed [15:0] mem [MEM_DEPTH];

  // Combinational helpers.
  logic [CH_W-1:0]    ch_in_idx;
  logic               ch_in_ok;
  logic               pluck_start;
  logic [AW-1:0]      wi_cur;
  logic [PW:0]        pos_raw, pos_adj;
  logic [AW-1:0]      rd_idx;
  logic               rd_ok;
  logic [MAW-1:0]     rd_addr, wr_addr;
  logic signed [15:0] s_cur;
  logic [16:0]        w0;
  logic signed [33:0] p0, p1;
  logic signed [33:0] lf_a, lf_b, bf_a, bf_b, fb_p, wv_p;
  logic [15:0]        one_minus_d, one_minus_a;
  logic [31:0]        x1, x2, x3;
  logic signed [15:0] nz;
  logic signed [15:0] lf_new, bf_new;
  logic               burst_on;
  logic               mem_we;
  logic signed [15:0] wval;

  assign ch_in_idx   = CH_W'(in_data.channel);
  assign ch_in_ok    = {31'b0, in_data.channel} < 32'(CHANNELS);
  assign pluck_start = (in_data.trigger > 16'sd0) && (prev_r[ch_in_idx] <= 16'sd0);

  // Read position, wrapped into the line.
  assign wi_cur  = wi_r[ch_idx_r];
  assign pos_raw = {1'b0, wi_cur, 16'b0} + SPAN - (PW + 1)'(red_r);
  assign pos_adj = (pos_raw >= SPAN) ? (pos_raw - SPAN) : pos_raw;

  // Entries not yet written since reset read as zero.
  assign rd_idx  = cmd.rd1 ? i1_r : i0_r;
  assign rd_ok   = wrap_r[ch_idx_r] || (rd_idx < wi_cur);
  assign rd_addr = MAW'({ch_idx_r, rd_idx});
  assign wr_addr = MAW'({ch_idx_r, wi_cur});

  assign s_cur = rvalid_r ? rdata_r : 16'sd0;
  assign w0    = 17'h10000 - {1'b0, frac_r};
  assign p0    = s_cur * $signed({1'b0, w0});
  assign p1    = s_cur * $signed({2'b0, frac_r});

  // Loop and excitation lowpass filters.
  assign one_minus_d = 16'h8000 - {1'b0, damp_r};
  assign one_minus_a = 16'h8000 - {1'b0, excite_r};
  assign lf_a   = y_r * $signed({1'b0, one_minus_d});
  assign lf_b   = lf_r[ch_idx_r] * $signed({1'b0, damp_r});
  assign lf_new = rnd_sat(lf_a + lf_b, 15);

  assign x1 = seed_r[ch_idx_r] ^ (seed_r[ch_idx_r] << 13);
  assign x2 = x1 ^ (x1 >> 17);
  assign x3 = x2 ^ (x2 << 5);
  assign nz = $signed(x3[31:16]);

  assign bf_a   = bf_r[ch_idx_r] * $signed({1'b0, excite_r});
  assign bf_b   = nz * $signed({1'b0, one_minus_a});
  assign bf_new = rnd_sat(bf_a + bf_b, 15);

  assign fb_p = lf_r[ch_idx_r] * $signed({1'b0, decay_r});
  assign wv_p = bf_r[ch_idx_r] * trig_r;

  assign burst_on = (burst_r[ch_idx_r] != 13'd0);
  assign mem_we   = cmd.write && ch_ok_r;
  assign wval     = burst_on ? wv_r : fb_r;

  assign red_step = SPAN64 << (red_cnt_r - RCW'(1));

  // Delay memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wval;
    if (cmd.rd0 || cmd.rd1) begin
      rdata_r  <= mem[rd_addr];
      rvalid_r <= rd_ok;
    end
  end

  // Configuration registers and the delay reduction modulo the line span.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pluck_r   <= pss_pkg::PLUCK_LENGTH_RST;
      damp_r    <= pss_pkg::LOOP_DAMPING_RST;
      decay_r   <= pss_pkg::LOOP_DECAY_RST;
      excite_r  <= pss_pkg::EXCITE_COEF_RST;
      red_r     <= RED_RESET;
      red_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pss_pkg::CFG_DELAY_LENGTH: begin
          red_r     <= cfg_data[27:0];
          red_cnt_r <= RCW'(RED_STEPS);
        end
        pss_pkg::CFG_PLUCK_LENGTH: pluck_r  <= cfg_data[12:0];
        pss_pkg::CFG_LOOP_DAMPING: damp_r   <= cfg_data[14:0];
        pss_pkg::CFG_LOOP_DECAY:   decay_r  <= cfg_data[15:0];
        pss_pkg::CFG_EXCITE_COEF:  excite_r <= cfg_data[14:0];
        default: ;
      endcase
    end else if (red_cnt_r != '0) begin
      if (64'(red_r) >= red_step) red_r <= red_r - 28'(red_step);
      red_cnt_r <= red_cnt_r - RCW'(1);
    end
  end

  // Per-channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lf_r[c]    <= '0;
        bf_r[c]    <= '0;
        prev_r[c]  <= '0;
        wi_r[c]    <= '0;
        wrap_r[c]  <= 1'b0;
        burst_r[c] <= '0;
        seed_r[c]  <= pss_pkg::SEED_INIT;
      end
    end else begin
      if (cmd.accept && ch_in_ok) begin
        prev_r[ch_in_idx] <= in_data.trigger;
        if (pluck_start) begin
          burst_r[ch_in_idx] <= pluck_r;
          bf_r[ch_in_idx]    <= '0;
          seed_r[ch_in_idx]  <= pss_pkg::SEED_INIT;
        end
      end
      if (cmd.filt && ch_ok_r) begin
        lf_r[ch_idx_r] <= lf_new;
        if (burst_on) begin
          seed_r[ch_idx_r] <= x3;
          bf_r[ch_idx_r]   <= bf_new;
        end
      end
      if (mem_we) begin
        if (wi_cur == LAST_IDX) begin
          wi_r[ch_idx_r]   <= '0;
          wrap_r[ch_idx_r] <= 1'b1;
        end else begin
          wi_r[ch_idx_r] <= wi_cur + AW'(1);
        end
        if (burst_on) burst_r[ch_idx_r] <= burst_r[ch_idx_r] - 13'd1;
      end
    end
  end

  // Item pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r     <= in_data.channel;
      ch_idx_r <= ch_in_idx;
      ch_ok_r  <= ch_in_ok;
      trig_r   <= in_data.trigger;
    end
    if (cmd.addr) begin
      i0_r   <= pos_adj[PW-1:16];
      i1_r   <= (pos_adj[PW-1:16] == LAST_IDX) ? '0 : pos_adj[PW-1:16] + AW'(1);
      frac_r <= pos_adj[15:0];
    end
    if (cmd.rd1)  prod0_r <= p0;
    if (cmd.intp) sum_r   <= prod0_r + p1;
    if (cmd.ysat) y_r     <= rnd_sat(sum_r, 16);
    if (cmd.gain) begin
      fb_r <= rnd_sat(fb_p, 15);
      wv_r <= rnd_sat(wv_p, 15);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.write) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_data_r.channel_out <= ch_r;
      out_data_r.sample_out  <= ch_ok_r ? y_r : 16'sd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.red_busy  = (red_cnt_r != '0);
  assign status.out_free  = !out_valid_r || out_ready;

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // No item starts while the delay is still being reduced.
  a_accept_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> red_cnt_r == '0)
    else $error("item accepted during delay reduction");

  // The reduction counts down by one in each cycle without a register write.
  a_red_count: assert property (@(posedge clk) disable iff (!rst_n)
    (red_cnt_r != '0) && !cfg_we
    |=> red_cnt_r == $past(red_cnt_r) - RCW'(1))
    else $error("delay reduction counter skipped");

endmodule

// ----- rtl/core/plucked_string_synth_top.sv -----
// Top level of the plucked string synthesiser: controller and datapath.
//
//  Port group  Direction  Handshake          Contents
//  in_*        input      in_valid/in_ready  channel, trigger sample
//  out_*       output     out_valid/out_ready channel_out, sample_out
//  cfg_*       input      cfg_we             register index and write data
//
// Each item passes from one input transfer to the next through an idle state
// and eight steps, set by the single read port of the delay memory and by
// one multiplication stage per filter step.
// Results wait in an output register, so a new item is taken while the last
// result is still held; a full output register stalls the write step only.
// Reset is synchronous and active low. The delay memory needs no clearing
// pass: per-channel fill tracking makes entries not yet written read as zero.
// After a delay_length write the input is held off while the delay is reduced
// modulo the line span; at the default depth no reduction runs.
module plucked_string_synth_top #(
  parameter int DELAY_DEPTH = 4096,
  parameter int CHANNELS    = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pss_pkg::in_item_t              in_data,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output pss_pkg::out_item_t             out_data,
  // Configuration port.
  input  logic                           cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0] cfg_data
);

  // The controller steps through the sequence; the datapath reports whether
  // the delay reduction is still running and whether the output is free.
  pss_pkg::pss_cmd_t    cmd;
  pss_pkg::pss_status_t status;

  pss_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // The datapath holds the delay lines, the per-channel filter and noise
  // state, the configuration registers and the output register.
  pss_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
